// ===== hdl/esort_pkg.sv =====
// Package for the exchange sort engine: sizes, payload types, the control
// state enum and the control word handed to every sort cell.
// No dependencies; every other file refers to it by scoped names.
package esort_pkg;

  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Control word broadcast to the cell row.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== hdl/esort_if.sv =====
// Valid/ready channel interfaces for the exchange sort engine.
// Depends on esort_pkg for the payload types.
interface esort_in_if;
  logic                  valid;
  logic                  ready;
  esort_pkg::value_t     value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface esort_out_if;
  logic                  valid;
  logic                  ready;
  esort_pkg::value_t     sorted_value;
  logic                  last_out;
  logic                  overflowed;

  modport source (output valid, output sorted_value, output last_out,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input overflowed, output ready);
endinterface

// ===== hdl/esort_cell.sv =====
// One cell of the insertion sort row: holds one value, compares it with the
// incoming item and takes its left or right neighbor's value as needed.
// Depends on esort_pkg.
module esort_cell (
  input  logic                  clk,
  input  esort_pkg::cell_ctl_t  ctl,
  input  esort_pkg::value_t     in_value,
  input  logic                  occupied,
  input  esort_pkg::value_t     prev_value,
  input  logic                  prev_gt,
  input  esort_pkg::value_t     next_value,
  output esort_pkg::value_t     value,
  output logic                  gt
);

  esort_pkg::value_t value_r;
  esort_pkg::value_t value_nxt;

  // An empty cell acts as if it held a value above every input.
  assign gt    = !occupied || (value_r > in_value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl.insert && gt) begin
      value_nxt = prev_gt ? prev_value : in_value;
    end else if (ctl.shift) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== hdl/exchange_sort_engine_top.sv =====
// Exchange sort engine: sorts a run of signed 32-bit values in ascending order.
// Items arrive on in_ch (value, last). Each accepted value is inserted into a
// row of DEPTH compare cells in the same cycle, so loading takes one item per
// cycle. The item with last set ends the run; from the next cycle on the run
// is given out on out_ch, smallest first, one item per cycle while the
// receiver is ready, with last_out on the final item. in_ch.ready is low
// while the run drains; the drain is paced by the left shift of the cell row.
// At most DEPTH values are kept; further values of the run are dropped and
// every result of that run carries overflowed. A stalled receiver simply
// holds the head cell, and the row shifts only when an item is taken.
// Reset (rst_n low, synchronous) empties the row and returns the block to
// loading; cell contents are not cleared, an occupancy count marks them.
// Depends on esort_pkg, esort_if and esort_cell.
module exchange_sort_engine_top (
  input  logic               clk,
  input  logic               rst_n,
  esort_in_if.sink           in_ch,
  esort_out_if.source        out_ch
);

  localparam int DEPTH = esort_pkg::DEPTH;
  localparam int CNT_W = esort_pkg::CNT_W;

  esort_pkg::state_t    state_r;
  esort_pkg::state_t    state_nxt;
  esort_pkg::count_t    count_r;
  esort_pkg::count_t    count_nxt;
  logic                 ovf_r;
  logic                 ovf_nxt;
  esort_pkg::cell_ctl_t ctl;

  esort_pkg::value_t    vals [DEPTH];
  logic                 gts  [DEPTH];

  logic in_acc;
  logic out_acc;
  logic full;
  logic final_out;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign final_out = (count_r == CNT_W'(1));
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      esort_pkg::ST_LOAD: begin
        if (in_acc && in_ch.last) state_nxt = esort_pkg::ST_DRAIN;
      end
      esort_pkg::ST_DRAIN: begin
        if (out_acc && final_out) state_nxt = esort_pkg::ST_LOAD;
      end
      default: state_nxt = esort_pkg::ST_LOAD;
    endcase
  end

  // Outputs and cell control. Ready and valid are constant within a state,
  // so the control terms use the other side of each handshake directly.
  always_comb begin
    in_ch.ready         = 1'b0;
    out_ch.valid        = 1'b0;
    ctl                 = '0;
    unique case (state_r)
      esort_pkg::ST_LOAD: begin
        in_ch.ready = 1'b1;
        ctl.insert  = in_ch.valid && !full;
      end
      esort_pkg::ST_DRAIN: begin
        out_ch.valid = 1'b1;
        ctl.shift    = out_ch.ready;
      end
      default: ;
    endcase
    out_ch.sorted_value = vals[0];
    out_ch.last_out     = final_out;
    out_ch.overflowed   = ovf_r;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (ctl.insert) count_nxt = count_r + CNT_W'(1);
    if (in_acc && full) ovf_nxt = 1'b1;
    if (ctl.shift) begin
      count_nxt = count_r - CNT_W'(1);
      if (final_out) ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esort_pkg::ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    esort_pkg::value_t prev_value;
    logic              prev_gt;
    esort_pkg::value_t next_value;

    if (i == 0) begin : g_head
      assign prev_value = in_ch.value;
      assign prev_gt    = 1'b1;
    end else begin : g_body
      assign prev_value = vals[i-1];
      assign prev_gt    = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = vals[i];
    end else begin : g_inner
      assign next_value = vals[i+1];
    end

    esort_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .in_value   (in_ch.value),
      .occupied   (count_r > CNT_W'(i)),
      .prev_value (prev_value),
      .prev_gt    (prev_gt),
      .next_value (next_value),
      .value      (vals[i]),
      .gt         (gts[i])
    );
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input and output active together");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (count_r != '0))
    else $error("draining an empty cell row");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last) |=> out_ch.valid)
    else $error("run end did not start output");

  a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_out) |=> in_ch.ready)
    else $error("block did not return to loading");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_out) |=>
      (out_ch.sorted_value >= $past(out_ch.sorted_value)))
    else $error("results not in ascending order");
`endif

endmodule
